### design/pts_pkg.sv
package pts_pkg;

	localparam int TASK_SLOTS_DEF = 8;
	localparam logic [15:0] QUANTUM_RESET = 16'd10;

	typedef enum logic [2:0] {
		FN_TICK    = 3'd0,
		FN_DELAY   = 3'd1,
		FN_CANCEL  = 3'd2,
		FN_ADD     = 3'd3,
		FN_REMOVE  = 3'd4,
		FN_SETPRIO = 3'd5,
		FN_SUSPEND = 3'd6,
		FN_RESUME  = 3'd7
	} func_t;

	// per-cell command from the sequencer
	typedef struct packed {
		logic wr;       // take ownership of this level
		logic clr;      // leave this level
		logic drop_tid; // leave this level if the given task owns it
	} cell_ctl_t;

endpackage

### design/pts_level_cell.sv
module pts_level_cell #(
	parameter int TASK_SLOTS = pts_pkg::TASK_SLOTS_DEF,
	parameter int IDX        = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pts_pkg::cell_ctl_t            ctl,
	input  logic [$clog2(TASK_SLOTS)-1:0] wr_owner,
	input  logic [$clog2(TASK_SLOTS)-1:0] tid,
	input  logic [TASK_SLOTS-1:0]         qual,
	input  logic                          tok_in,
	output logic                          pass_out,
	output logic                          hit,
	output logic                          valid,
	output logic [$clog2(TASK_SLOTS)-1:0] owner
);
	import pts_pkg::*;

	localparam int TID_W = $clog2(TASK_SLOTS);
	localparam logic VALID_RST = (IDX >= TASK_SLOTS - 2);
	localparam logic [TID_W-1:0] OWNER_RST = (IDX == TASK_SLOTS - 1) ? TID_W'(1) : '0;

	logic             valid_q;
	logic [TID_W-1:0] owner_q;
	logic             tok_q;
	logic             ready;

	assign ready    = valid_q & qual[owner_q];
	assign hit      = tok_q & ready;
	assign pass_out = tok_q & ~ready;
	assign valid    = valid_q;
	assign owner    = owner_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= VALID_RST;
			owner_q <= OWNER_RST;
			tok_q   <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (ctl.wr) begin
				valid_q <= 1'b1;
				owner_q <= wr_owner;
			end else if (ctl.clr || (ctl.drop_tid && owner_q == tid)) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

### design/priority_task_scheduler.sv
// Channel   Direction  Signals                                    Beat taken when
// command   in         start, busy, func, task_id, level,         start & !busy
//                      wait_ticks
// result    out        done, status, new_task_id, running_task,   done (one cycle)
//                      switched
// config    in         cfg_valid, cfg_ready, cfg_data             cfg_valid & cfg_ready
//
// Sequence: a command without a scan goes from accept via ST_EXEC to its result strobe.
// A command that scans goes via ST_EXEC and ST_QUAL to ST_SCAN, where it stays while the
// scan token visits 1 to TASK_SLOTS level cells, until one hits or it leaves the row.
// The token walks the row of level cells one cell per clock.
// Reset: asynchronous, active low; tasks 0 and 1 active at the two lowest priority levels.
// The result receiver cannot stall; each result is shown for exactly one cycle.
// The config port is always ready.
module priority_task_scheduler #(
	parameter int TASK_SLOTS = pts_pkg::TASK_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [2:0]  task_id,
	input  logic [2:0]  level,
	input  logic [31:0] wait_ticks,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic        status,
	output logic [2:0]  new_task_id,
	output logic [2:0]  running_task,
	output logic        switched
);
	import pts_pkg::*;

	localparam int TID_W = $clog2(TASK_SLOTS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_QUAL,
		ST_SCAN
	} state_t;

	state_t state_q;

	// captured command beat
	func_t       func_q;
	logic [2:0]  tid_q;
	logic [2:0]  lvl_q;
	logic [31:0] dly_q;

	// task table and timers
	logic [TASK_SLOTS-1:0] active_q;
	logic [TASK_SLOTS-1:0] waiting_q;
	logic [TASK_SLOTS-1:0] held_q;
	logic [31:0]           wake_q [TASK_SLOTS];
	logic [TASK_SLOTS-1:0] qual_q;
	logic [TID_W-1:0]      current_q;
	logic [15:0]           slice_q;
	logic [31:0]           time_q;
	logic [15:0]           quantum_q;

	// result registers
	logic       done_q;
	logic       status_q;
	logic [2:0] new_id_q;
	logic       switched_q;

	// decoded command
	logic             tid_ok;
	logic             lvl_ok;
	logic [TID_W-1:0] tid_i;
	logic [TID_W-1:0] lvl_i;
	logic [15:0]      slice_inc;
	logic             lvl_busy;
	logic [TASK_SLOTS-1:0] free_vec;
	logic [TASK_SLOTS-1:0] free_oh;
	logic [TID_W-1:0]      free_idx;
	logic [TASK_SLOTS-1:0] own_vec;
	logic [TASK_SLOTS-1:0] own_oh;
	logic             add_ok;
	logic             move_ok;
	logic             cmd_err;
	logic             scan_req;
	logic [TASK_SLOTS-1:0] qualify;

	// level cell row
	cell_ctl_t             cell_ctl [TASK_SLOTS];
	logic [TID_W-1:0]      cell_wr_owner;
	logic [TASK_SLOTS-1:0] cell_tok;
	logic [TASK_SLOTS-1:0] cell_pass;
	logic [TASK_SLOTS-1:0] cell_hit;
	logic [TASK_SLOTS-1:0] cell_valid;
	logic [TID_W-1:0]      cell_owner [TASK_SLOTS];
	logic [TID_W-1:0]      hit_owner;
	logic                  exec;

	assign busy         = (state_q != ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign done         = done_q;
	assign status       = status_q;
	assign new_task_id  = new_id_q;
	assign running_task = 3'(current_q);
	assign switched     = switched_q;

	assign exec      = (state_q == ST_EXEC);
	assign tid_ok    = (32'(tid_q) < TASK_SLOTS);
	assign lvl_ok    = (32'(lvl_q) < TASK_SLOTS);
	assign tid_i     = TID_W'(tid_q);
	assign lvl_i     = TID_W'(lvl_q);
	assign slice_inc = slice_q + 16'd1;
	assign lvl_busy  = cell_valid[lvl_i];

	// lowest free task slot and lowest level owned by the addressed task
	assign free_vec = ~active_q;
	assign free_oh  = free_vec & (~free_vec + TASK_SLOTS'(1));
	assign own_oh   = own_vec & (~own_vec + TASK_SLOTS'(1));

	always_comb begin
		free_idx  = '0;
		hit_owner = '0;
		for (int i = 0; i < TASK_SLOTS; i++) begin
			own_vec[i] = cell_valid[i] && (cell_owner[i] == tid_i);
			if (free_oh[i])
				free_idx = free_idx | TID_W'(i);
			if (cell_hit[i])
				hit_owner = hit_owner | cell_owner[i];
			qualify[i] = (active_q[i] & ~waiting_q[i] & ~held_q[i])
				| (waiting_q[i] & (time_q >= wake_q[i]));
		end
	end

	assign add_ok  = lvl_ok && !lvl_busy && (free_vec != '0);
	assign move_ok = tid_ok && lvl_ok && !lvl_busy;

	always_comb begin
		cmd_err  = 1'b0;
		scan_req = 1'b0;
		case (func_q)
			FN_TICK: begin
				scan_req = (slice_inc >= quantum_q);
			end
			FN_ADD: begin
				cmd_err = !add_ok;
			end
			FN_RESUME: begin
				cmd_err = !tid_ok;
			end
			FN_SETPRIO: begin
				cmd_err  = !(tid_ok && lvl_ok);
				scan_req = tid_ok && lvl_ok;
			end
			FN_DELAY, FN_CANCEL, FN_REMOVE, FN_SUSPEND: begin
				cmd_err  = !tid_ok;
				scan_req = tid_ok;
			end
			default: begin
				cmd_err = 1'b1;
			end
		endcase
	end

	// owner written into a level: the new slot on add, the task itself on a move
	assign cell_wr_owner = (func_q == FN_ADD) ? free_idx : tid_i;

	always_comb begin
		for (int i = 0; i < TASK_SLOTS; i++) begin
			cell_ctl[i].wr = exec && (TID_W'(i) == lvl_i)
				&& (((func_q == FN_ADD) && add_ok) || ((func_q == FN_SETPRIO) && move_ok));
			cell_ctl[i].clr      = exec && (func_q == FN_SETPRIO) && move_ok && own_oh[i];
			cell_ctl[i].drop_tid = exec && (func_q == FN_REMOVE) && tid_ok;
		end
	end

	// token enters level 0 and walks toward the lowest priority
	always_comb begin
		cell_tok[0] = (state_q == ST_QUAL);
		for (int i = 1; i < TASK_SLOTS; i++)
			cell_tok[i] = cell_pass[i-1];
	end

	for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
		pts_level_cell #(
			.TASK_SLOTS(TASK_SLOTS),
			.IDX       (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cell_ctl[g]),
			.wr_owner(cell_wr_owner),
			.tid     (tid_i),
			.qual    (qual_q),
			.tok_in  (cell_tok[g]),
			.pass_out(cell_pass[g]),
			.hit     (cell_hit[g]),
			.valid   (cell_valid[g]),
			.owner   (cell_owner[g])
		);
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			quantum_q <= cfg_data;
		end
	end

	// capture the command beat
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			func_q <= func_t'(func);
			tid_q  <= task_id;
			lvl_q  <= level;
			dly_q  <= wait_ticks;
		end
	end

	// sequencer, task table and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			active_q   <= TASK_SLOTS'(3);
			waiting_q  <= '0;
			held_q     <= '0;
			for (int i = 0; i < TASK_SLOTS; i++)
				wake_q[i] <= '0;
			qual_q     <= '0;
			current_q  <= '0;
			slice_q    <= '0;
			time_q     <= '0;
			done_q     <= 1'b0;
			status_q   <= 1'b0;
			new_id_q   <= '0;
			switched_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					status_q   <= cmd_err;
					switched_q <= scan_req;
					new_id_q   <= '0;
					case (func_q)
						FN_TICK: begin
							time_q  <= time_q + 32'd1;
							slice_q <= scan_req ? 16'd0 : slice_inc;
						end
						FN_DELAY: begin
							if (tid_ok) begin
								wake_q[tid_i]    <= time_q + dly_q;
								waiting_q[tid_i] <= 1'b1;
							end
						end
						FN_CANCEL: begin
							if (tid_ok)
								waiting_q[tid_i] <= 1'b0;
						end
						FN_ADD: begin
							if (add_ok) begin
								active_q[free_idx] <= 1'b1;
								new_id_q           <= 3'(free_idx);
							end
						end
						FN_REMOVE: begin
							if (tid_ok)
								active_q[tid_i] <= 1'b0;
						end
						FN_SUSPEND: begin
							if (tid_ok)
								held_q[tid_i] <= 1'b1;
						end
						FN_RESUME: begin
							if (tid_ok)
								held_q[tid_i] <= 1'b0;
						end
						default: begin
						end
					endcase
					if (scan_req) begin
						state_q <= ST_QUAL;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_QUAL: begin
					// freeze readiness for the walk; the token enters level 0 now
					qual_q  <= qualify;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (cell_hit != '0) begin
						current_q            <= hit_owner;
						waiting_q[hit_owner] <= 1'b0;
						state_q              <= ST_IDLE;
						done_q               <= 1'b1;
					end else if (cell_pass[TASK_SLOTS-1]) begin
						// nothing qualifies: keep the current task
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// at most one level claims the scan
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_hit))
		else $error("more than one level hit in one cycle");

	// the token never runs outside a scan
	a_tok_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_pass != '0 || cell_hit != '0) |-> state_q == ST_SCAN)
		else $error("scan token outside a scan");

	// a result strobe only as the sequencer returns to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE && $past(state_q) != ST_IDLE)
		else $error("result strobe out of sequence");

	// a scanning command never reports an error
	a_scan_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && switched_q) |-> !status_q)
		else $error("scan reported with error status");

	// an accepted command keeps the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not start");

endmodule

### verif/priority_task_scheduler_tb.sv
module priority_task_scheduler_tb;
	import pts_pkg::*;

	localparam int SLOTS = TASK_SLOTS_DEF;
	localparam int CYCLE_LIMIT = 300000;
	localparam int IDLE_PCT = 23;
	localparam int PHASE_CMDS = 205;
	localparam int NUM_PHASES = 6;
	localparam int CALM_PHASE = 3;   // this phase never idles the command side

	// One result beat, field by field as the result ports carry it.
	typedef struct packed {
		logic       status;
		logic [2:0] new_id;
		logic [2:0] running;
		logic       sw;
	} sched_result_t;

	// One row of the directed table. When pinned is set, want is the
	// result typed in by hand; otherwise the scheduler model decides.
	typedef struct {
		func_t         fn;
		logic [2:0]    tid;
		logic [2:0]    lvl;
		logic [31:0]   dly;
		bit            pinned;
		sched_result_t want;
	} cmd_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  func;
	logic [2:0]  task_id;
	logic [2:0]  level;
	logic [31:0] wait_ticks;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        done;
	logic        status;
	logic [2:0]  new_task_id;
	logic [2:0]  running_task;
	logic        switched;

	// Scheduler model state, kept in step with every accepted command beat.
	bit   [SLOTS-1:0] sched_active;
	bit   [SLOTS-1:0] sched_delayed;
	bit   [SLOTS-1:0] sched_held;
	logic [31:0]      sched_wake [SLOTS];
	bit   [SLOTS-1:0] lvl_taken;
	logic [2:0]       lvl_owner [SLOTS];
	logic [2:0]       sched_current;
	logic [15:0]      sched_slice;
	logic [31:0]      sched_now;
	logic [15:0]      sched_quantum;

	sched_result_t pending_results [$];
	sched_result_t head;

	int errors;
	int cycle_count;
	int cmds_by_func [8];
	int scans_seen;
	int refused_adds;
	int quanta_used;

	// Directed table: reset state first, then every command, the add
	// refusals, wake-time wrap, equal wake time, moving an owned level,
	// claiming a level for a task that owns none, waking an inactive task,
	// and finally the tick that runs out the reset time slice.
	cmd_row_t directed_rows [25] = '{
		'{FN_TICK,    3'd0, 3'd0, 32'd0,        1'b1, '{1'b0, 3'd0, 3'd0, 1'b0}},
		'{FN_ADD,     3'd0, 3'd0, 32'd0,        1'b1, '{1'b0, 3'd2, 3'd0, 1'b0}},
		'{FN_ADD,     3'd0, 3'd0, 32'd0,        1'b1, '{1'b1, 3'd0, 3'd0, 1'b0}},
		'{FN_ADD,     3'd7, 3'd7, 32'hFFFFFFFF, 1'b1, '{1'b1, 3'd0, 3'd0, 1'b0}},
		'{FN_SUSPEND, 3'd2, 3'd0, 32'd0,        1'b1, '{1'b0, 3'd0, 3'd0, 1'b1}},
		'{FN_RESUME,  3'd2, 3'd0, 32'd0,        1'b1, '{1'b0, 3'd0, 3'd0, 1'b0}},
		'{FN_CANCEL,  3'd2, 3'd0, 32'd0,        1'b1, '{1'b0, 3'd0, 3'd2, 1'b1}},
		'{FN_DELAY,   3'd2, 3'd0, 32'hFFFFFFFF, 1'b1, '{1'b0, 3'd0, 3'd2, 1'b1}},
		'{FN_DELAY,   3'd2, 3'd0, 32'd4,        1'b1, '{1'b0, 3'd0, 3'd0, 1'b1}},
		'{FN_TICK,    3'd0, 3'd0, 32'd0,        1'b0, '0},
		'{FN_TICK,    3'd0, 3'd0, 32'd0,        1'b0, '0},
		'{FN_TICK,    3'd0, 3'd0, 32'd0,        1'b0, '0},
		'{FN_TICK,    3'd0, 3'd0, 32'd0,        1'b0, '0},
		'{FN_CANCEL,  3'd5, 3'd0, 32'd0,        1'b0, '0},
		'{FN_SETPRIO, 3'd2, 3'd7, 32'd0,        1'b0, '0},
		'{FN_SETPRIO, 3'd2, 3'd3, 32'd0,        1'b0, '0},
		'{FN_SETPRIO, 3'd5, 3'd1, 32'd0,        1'b0, '0},
		'{FN_DELAY,   3'd5, 3'd0, 32'd0,        1'b0, '0},
		'{FN_REMOVE,  3'd2, 3'd0, 32'd0,        1'b0, '0},
		'{FN_ADD,     3'd0, 3'd3, 32'd0,        1'b0, '0},
		'{FN_TICK,    3'd0, 3'd0, 32'd0,        1'b0, '0},
		'{FN_TICK,    3'd0, 3'd0, 32'd0,        1'b0, '0},
		'{FN_TICK,    3'd0, 3'd0, 32'd0,        1'b0, '0},
		'{FN_TICK,    3'd0, 3'd0, 32'd0,        1'b0, '0},
		'{FN_TICK,    3'd0, 3'd0, 32'd0,        1'b0, '0}
	};

	priority_task_scheduler uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.task_id      (task_id),
		.level        (level),
		.wait_ticks   (wait_ticks),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.done         (done),
		.status       (status),
		.new_task_id  (new_task_id),
		.running_task (running_task),
		.switched     (switched)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Walk the levels from the highest priority down and hand the CPU to the
	// first owner that is ready, or that is delayed with its wake time reached
	// (that one also leaves the delayed state). Keep the current task otherwise.
	function automatic void rescan_levels();
		logic [2:0] t;
		for (int lv = 0; lv < SLOTS; lv++) begin
			if (lvl_taken[lv]) begin
				t = lvl_owner[lv];
				if (sched_active[t] && !sched_delayed[t] && !sched_held[t]) begin
					sched_current = t;
					return;
				end
				if (sched_delayed[t] && sched_now >= sched_wake[t]) begin
					sched_delayed[t] = 1'b0;
					sched_current = t;
					return;
				end
			end
		end
	endfunction

	// Apply one command to the model and return the result beat it causes.
	// All task and level fields are 3 bits wide, so none is out of range here.
	function automatic sched_result_t schedule_cmd(input func_t fn, input logic [2:0] tid,
			input logic [2:0] lvl, input logic [31:0] dly);
		sched_result_t r;
		bit            scan;
		int            i;
		r = '0;
		scan = 1'b0;
		case (fn)
			FN_TICK: begin
				sched_slice = sched_slice + 16'd1;
				sched_now = sched_now + 32'd1;
				if (sched_slice >= sched_quantum) begin
					sched_slice = '0;
					scan = 1'b1;
				end
			end
			FN_DELAY: begin
				sched_wake[tid] = sched_now + dly;   // wraps at 32 bits
				sched_delayed[tid] = 1'b1;
				scan = 1'b1;
			end
			FN_CANCEL: begin
				sched_delayed[tid] = 1'b0;
				scan = 1'b1;
			end
			FN_ADD: begin
				i = 0;
				while (i < SLOTS && sched_active[i])
					i++;
				if (lvl_taken[lvl] || i >= SLOTS) begin
					r.status = 1'b1;
				end else begin
					sched_active[i] = 1'b1;
					lvl_taken[lvl] = 1'b1;
					lvl_owner[lvl] = 3'(i);
					r.new_id = 3'(i);
				end
			end
			FN_REMOVE: begin
				sched_active[tid] = 1'b0;
				for (int lv = 0; lv < SLOTS; lv++)
					if (lvl_taken[lv] && lvl_owner[lv] == tid)
						lvl_taken[lv] = 1'b0;
				scan = 1'b1;
			end
			FN_SETPRIO: begin
				// drop only the first level the task owns, then claim the new one
				if (!lvl_taken[lvl]) begin
					i = 0;
					while (i < SLOTS && !(lvl_taken[i] && lvl_owner[i] == tid))
						i++;
					if (i < SLOTS)
						lvl_taken[i] = 1'b0;
					lvl_taken[lvl] = 1'b1;
					lvl_owner[lvl] = tid;
				end
				scan = 1'b1;
			end
			FN_SUSPEND: begin
				sched_held[tid] = 1'b1;
				scan = 1'b1;
			end
			default: begin
				sched_held[tid] = 1'b0;
			end
		endcase
		if (scan)
			rescan_levels();
		r.running = sched_current;
		r.sw = scan;
		return r;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s is %0d, expected %0d", cycle_count, what, got,
			want);
		errors++;
	endtask

	// Present one command beat and hold it until the block takes it, then
	// advance the model and queue the result it must produce.
	task automatic issue(input func_t fn, input logic [2:0] tid, input logic [2:0] lvl,
			input logic [31:0] dly, input bit pinned, input sched_result_t want);
		sched_result_t r;
		start <= 1'b1;
		func <= fn;
		task_id <= tid;
		level <= lvl;
		wait_ticks <= dly;
		do @(posedge clk); while (busy !== 1'b0);
		r = schedule_cmd(fn, tid, lvl, dly);
		cmds_by_func[fn]++;
		if (r.sw)
			scans_seen++;
		if (fn == FN_ADD && r.status)
			refused_adds++;
		pending_results.push_back(pinned ? want : r);
	endtask

	// Drop start and sit out a few cycles.
	task automatic idle_gap(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Write the time slice length while the block is idle.
	task automatic write_quantum(input logic [15:0] q);
		cfg_valid <= 1'b1;
		cfg_data <= q;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sched_quantum = q;
		quanta_used++;
		cfg_valid <= 1'b0;
	endtask

	// Result side: the block shows each beat for exactly one cycle, so check
	// it at the edge that closes that cycle against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				report("result beat with none pending, running_task", running_task, 0);
			end else begin
				head = pending_results.pop_front();
				if (status !== head.status)
					report("status", status, head.status);
				if (new_task_id !== head.new_id)
					report("new_task_id", new_task_id, head.new_id);
				if (running_task !== head.running)
					report("running_task", running_task, head.running);
				if (switched !== head.sw)
					report("switched", switched, head.sw);
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("FAIL priority_task_scheduler");
			$finish;
		end
	end

	initial begin
		logic [15:0] quanta [NUM_PHASES];
		func_t       fn;
		logic [2:0]  tid;
		logic [2:0]  lvl;
		logic [31:0] dly;
		int          roll;

		// Drive every input to a known value before the first edge.
		arst_n = 1'b0;
		start = 1'b0;
		func = FN_TICK;
		task_id = '0;
		level = '0;
		wait_ticks = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		errors = 0;
		cycle_count = 0;
		scans_seen = 0;
		refused_adds = 0;
		quanta_used = 0;
		foreach (cmds_by_func[i])
			cmds_by_func[i] = 0;

		// Model reset: tasks 0 and 1 live at the two lowest priority levels.
		sched_active = '0;
		sched_delayed = '0;
		sched_held = '0;
		lvl_taken = '0;
		foreach (sched_wake[i]) begin
			sched_wake[i] = '0;
			lvl_owner[i] = '0;
		end
		sched_active[0] = 1'b1;
		sched_active[1] = 1'b1;
		lvl_taken[SLOTS-2] = 1'b1;
		lvl_owner[SLOTS-2] = 3'd0;
		lvl_taken[SLOTS-1] = 1'b1;
		lvl_owner[SLOTS-1] = 3'd1;
		sched_current = '0;
		sched_slice = '0;
		sched_now = '0;
		sched_quantum = QUANTUM_RESET;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, still at the reset quantum.
		foreach (directed_rows[i]) begin
			issue(directed_rows[i].fn, directed_rows[i].tid, directed_rows[i].lvl,
				directed_rows[i].dly, directed_rows[i].pinned, directed_rows[i].want);
			if ($urandom_range(99) < IDLE_PCT)
				idle_gap($urandom_range(1, 14));
		end
		start <= 1'b0;

		// Random phases, one quantum each: shortest, zero (scan every tick),
		// longest, a short one, a random one, and back to the reset value.
		quanta[0] = 16'd1;
		quanta[1] = 16'd0;
		quanta[2] = 16'hFFFF;
		quanta[3] = 16'd3;
		quanta[4] = 16'($urandom_range(2, 40));
		quanta[5] = QUANTUM_RESET;

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_results();
			write_quantum(quanta[p]);
			for (int k = 0; k < PHASE_CMDS; k++) begin
				// Weight ticks and adds so time advances and slots churn.
				roll = $urandom_range(99);
				if (roll < 34)
					fn = FN_TICK;
				else if (roll < 44)
					fn = FN_DELAY;
				else if (roll < 52)
					fn = FN_CANCEL;
				else if (roll < 66)
					fn = FN_ADD;
				else if (roll < 74)
					fn = FN_REMOVE;
				else if (roll < 84)
					fn = FN_SETPRIO;
				else if (roll < 92)
					fn = FN_SUSPEND;
				else
					fn = FN_RESUME;
				tid = 3'($urandom_range(7));
				lvl = 3'($urandom_range(7));
				// Mostly short delays so wake times pass; now and then a huge one.
				roll = $urandom_range(99);
				if (roll < 70)
					dly = $urandom_range(0, 24);
				else if (roll < 90)
					dly = $urandom_range(25, 400);
				else
					dly = $urandom;
				issue(fn, tid, lvl, dly, 1'b0, '0);
				if (p != CALM_PHASE && $urandom_range(99) < IDLE_PCT)
					idle_gap($urandom_range(1, 14));
			end
			start <= 1'b0;
		end

		// Let the last result land, then give the block a scan's worth of cycles.
		drain_results();
		repeat (SLOTS + 4) @(posedge clk);

		$display("ran %0d ticks, %0d delays, %0d cancels, %0d adds (%0d refused), %0d removes",
			cmds_by_func[FN_TICK], cmds_by_func[FN_DELAY], cmds_by_func[FN_CANCEL],
			cmds_by_func[FN_ADD], refused_adds, cmds_by_func[FN_REMOVE]);
		$display("plus %0d priority moves, %0d suspends, %0d resumes; %0d scans, %0d quanta",
			cmds_by_func[FN_SETPRIO], cmds_by_func[FN_SUSPEND], cmds_by_func[FN_RESUME],
			scans_seen, quanta_used);
		if (errors == 0)
			$display("PASS priority_task_scheduler");
		else
			$display("FAIL priority_task_scheduler");
		$finish;
	end

endmodule
